@@ src/chacha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_pkg: shared types and functions of the ChaCha permutation
// Holds the transaction structs, the working state type and the half-round
// function that every pipeline stage applies.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  // Each double round is split into four half-rounds: column first half,
  // column second half, diagonal first half, diagonal second half.
  localparam int NUM_STAGES    = 4 * DOUBLE_ROUNDS;

  localparam int ROT_A = 16;
  localparam int ROT_B = 12;
  localparam int ROT_C = 8;
  localparam int ROT_D = 7;

  typedef struct packed {
    logic [63:0] in_block0;
    logic [63:0] in_block1;
    logic [63:0] in_block2;
    logic [63:0] in_block3;
    logic [63:0] in_block4;
    logic [63:0] in_block5;
    logic [63:0] in_block6;
    logic [63:0] in_block7;
  } in_t;

  typedef struct packed {
    logic [63:0] out_block0;
    logic [63:0] out_block1;
    logic [63:0] out_block2;
    logic [63:0] out_block3;
    logic [63:0] out_block4;
    logic [63:0] out_block5;
    logic [63:0] out_block6;
    logic [63:0] out_block7;
  } out_t;

  typedef logic [15:0][31:0] state_t;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
    rol32 = (v << n) | (v >> (32 - n));
  endfunction

  function automatic state_t unpack_block(input in_t b);
    state_t s;
    s[0]  = b.in_block0[31:0];
    s[1]  = b.in_block0[63:32];
    s[2]  = b.in_block1[31:0];
    s[3]  = b.in_block1[63:32];
    s[4]  = b.in_block2[31:0];
    s[5]  = b.in_block2[63:32];
    s[6]  = b.in_block3[31:0];
    s[7]  = b.in_block3[63:32];
    s[8]  = b.in_block4[31:0];
    s[9]  = b.in_block4[63:32];
    s[10] = b.in_block5[31:0];
    s[11] = b.in_block5[63:32];
    s[12] = b.in_block6[31:0];
    s[13] = b.in_block6[63:32];
    s[14] = b.in_block7[31:0];
    s[15] = b.in_block7[63:32];
    return s;
  endfunction

  function automatic out_t pack_block(input state_t s);
    out_t b;
    b.out_block0 = {s[1],  s[0]};
    b.out_block1 = {s[3],  s[2]};
    b.out_block2 = {s[5],  s[4]};
    b.out_block3 = {s[7],  s[6]};
    b.out_block4 = {s[9],  s[8]};
    b.out_block5 = {s[11], s[10]};
    b.out_block6 = {s[13], s[12]};
    b.out_block7 = {s[15], s[14]};
    return b;
  endfunction

  // One half of a column or diagonal round: the four quarter-rounds run side
  // by side, each doing two add, xor and rotate steps.
  function automatic state_t half_round(input state_t s, input logic diag,
                                        input logic second);
    state_t r;
    logic [1:0] ib;
    logic [1:0] ic;
    logic [1:0] id;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    r = s;
    for (int i = 0; i < 4; i++) begin
      ib = 2'(i + (diag ? 1 : 0));
      ic = 2'(i + (diag ? 2 : 0));
      id = 2'(i + (diag ? 3 : 0));
      a = s[i];
      b = s[{2'b01, ib}];
      c = s[{2'b10, ic}];
      d = s[{2'b11, id}];
      a = a + b;
      d = rol32(d ^ a, second ? ROT_C : ROT_A);
      c = c + d;
      b = rol32(b ^ c, second ? ROT_D : ROT_B);
      r[i]            = a;
      r[{2'b01, ib}]  = b;
      r[{2'b10, ic}]  = c;
      r[{2'b11, id}]  = d;
    end
    return r;
  endfunction

endpackage

@@ src/chacha_permutation_512.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_permutation_512: pipelined ChaCha permutation of a 512-bit block
// Applies the double rounds of the ChaCha core to each block, one half-round
// per register stage, without the final feed-forward addition.
// ----------------------------------------------------------------------------
// The block accepts one 64-byte transaction per clock while block_ready is
// high and returns its image under the ChaCha permutation once it has passed
// through every stage, one result transaction for every input. Words are
// little endian: word 2k sits in bits 31:0 of in_blockk and word 2k+1 in bits
// 63:32, and the result uses the same packing. The latency is set by the
// pipeline depth, one register stage per half quarter-round (two 32-bit
// adds deep). Every stage has its own valid bit and a stage takes new data
// whenever it is empty or its successor takes its contents, so bubbles
// collapse and input keeps flowing behind a stalled result until all stages
// are full. There is no state between transactions; reset only clears valid.
module chacha_permutation_512
  import chacha_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic block_valid,
  output logic block_ready,
  input  in_t  block_data,
  output logic perm_valid,
  input  logic perm_ready,
  output out_t perm_data
);

  state_t st [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   rdy;

  assign rdy[NUM_STAGES] = perm_ready;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    localparam logic DIAG   = ((g / 2) % 2) == 1;
    localparam logic SECOND = (g % 2) == 1;

    state_t src;
    logic   src_vld;

    if (g == 0) begin : g_first
      assign src     = unpack_block(block_data);
      assign src_vld = block_valid;
    end else begin : g_rest
      assign src     = st[g-1];
      assign src_vld = vld[g-1];
    end

    // A stage can load when it is empty or its data moves on this cycle.
    assign rdy[g] = !vld[g] || rdy[g+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (rdy[g]) begin
        vld[g] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g] && src_vld) begin
        st[g] <= half_round(src, DIAG, SECOND);
      end
    end
  end

  assign block_ready = rdy[0];
  assign perm_valid  = vld[NUM_STAGES-1];
  assign perm_data   = pack_block(st[NUM_STAGES-1]);

endmodule

@@ src/chacha_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_checker: port-level checks for the ChaCha permutation pipeline
// Watches the top-level ports and flags handshake and flow-control slips.
// ----------------------------------------------------------------------------
module chacha_checker
  import chacha_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic block_valid,
  input logic block_ready,
  input in_t  block_data,
  input logic perm_valid,
  input logic perm_ready,
  input out_t perm_data
);

  // An offered input transaction stays up with the same payload until taken.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    block_valid && !block_ready |=> block_valid && $stable(block_data))
    else $error("input transaction changed before acceptance");

  // A result that is not taken stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    perm_valid && !perm_ready |=> perm_valid)
    else $error("result transaction dropped before acceptance");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    perm_valid && !perm_ready |=> $stable(perm_data))
    else $error("result payload changed while stalled");

  // When the output drains, the whole pipeline moves and takes input.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    perm_ready |-> block_ready)
    else $error("input stalled while output is ready");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    rst |=> !perm_valid)
    else $error("result offered right after reset");

endmodule

bind chacha_permutation_512 chacha_checker u_chacha_checker (
  .clk         (clk),
  .rst         (rst),
  .block_valid (block_valid),
  .block_ready (block_ready),
  .block_data  (block_data),
  .perm_valid  (perm_valid),
  .perm_ready  (perm_ready),
  .perm_data   (perm_data)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the pipelined ChaCha permutation
// Pushes directed and random 512-bit blocks through the block with random
// gaps and stalls on both handshakes, and one long receiver hold-off. Every
// result is compared field by field against a predicted permutation image.
// ----------------------------------------------------------------------------
module tb_top;
  import chacha_pkg::*;

  // The slowest legal run (about 1320 blocks with the longest idle gaps on
  // each side, plus the pipeline and one long hold-off) stays far below
  // CYCLE_LIMIT, which leaves a wide margin.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BLOCKS = 1300;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_AFTER    = 300;
  localparam int HOLD_CYCLES   = 400;

  typedef logic [7:0][63:0] lanes_t;
  typedef logic [3:0][31:0] quad_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input of the block starts at a known value.
  logic block_valid = 1'b0;
  logic block_ready;
  in_t  block_data  = '0;
  logic perm_valid;
  logic perm_ready  = 1'b0;
  out_t perm_data;

  in_t  block_pending[$];
  out_t perm_expected[$];

  int   error_count   = 0;
  int   results_seen  = 0;
  int   cycle_count   = 0;
  int   gap_left      = 0;
  int   stall_left    = 0;
  int   hold_left     = 0;
  logic hold_off      = 1'b0;
  logic hold_done     = 1'b0;
  logic tx_burst      = 1'b0;
  logic rx_burst      = 1'b0;

  chacha_permutation_512 dut (
    .clk         (clk),
    .rst         (rst),
    .block_valid (block_valid),
    .block_ready (block_ready),
    .block_data  (block_data),
    .perm_valid  (perm_valid),
    .perm_ready  (perm_ready),
    .perm_data   (perm_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor. The 512-bit block is viewed as sixteen 32-bit words, two per
  // 64-bit field with the even word in the low half. Each double round runs
  // the four column quarter-rounds and then the four diagonal quarter-rounds.
  // There is no feed-forward of the input words.
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    logic [63:0] twice;
    twice = {v, v} << n;
    return twice[63:32];
  endfunction

  // Quarter-round on (a, b, c, d) held in q[0], q[1], q[2], q[3].
  function automatic quad_t quarter_mix(input quad_t q);
    quad_t m;
    m = q;
    m[0] = m[0] + m[1]; m[3] = rotl(m[3] ^ m[0], ROT_A);
    m[2] = m[2] + m[3]; m[1] = rotl(m[1] ^ m[2], ROT_B);
    m[0] = m[0] + m[1]; m[3] = rotl(m[3] ^ m[0], ROT_C);
    m[2] = m[2] + m[3]; m[1] = rotl(m[1] ^ m[2], ROT_D);
    return m;
  endfunction

  function automatic out_t chacha_image(input in_t blk);
    lanes_t      lanes;
    logic [31:0] w [16];
    quad_t       q;
    int          ia, ib, ic, id;
    out_t        res;
    lanes = blk;
    // Packed struct members run from the top down, so in_block0 is lane 7.
    for (int k = 0; k < 8; k++) begin
      w[2*k]   = lanes[7-k][31:0];
      w[2*k+1] = lanes[7-k][63:32];
    end
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      for (int diag = 0; diag < 2; diag++) begin
        for (int i = 0; i < 4; i++) begin
          ia = i;
          ib = 4  + ((i + diag)     % 4);
          ic = 8  + ((i + 2 * diag) % 4);
          id = 12 + ((i + 3 * diag) % 4);
          q = quarter_mix({w[id], w[ic], w[ib], w[ia]});
          w[ia] = q[0];
          w[ib] = q[1];
          w[ic] = q[2];
          w[id] = q[3];
        end
      end
    end
    for (int k = 0; k < 8; k++) begin
      lanes[7-k] = {w[2*k+1], w[2*k]};
    end
    res = lanes;
    return res;
  endfunction

  // Counts a failure and prints the first few of them.
  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s", what);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. The directed blocks hit the extremes of every field and the
  // carry-heavy patterns first; the random blocks follow, mostly dense random
  // data with some sparse and some nearly-all-ones blocks mixed in.
  // --------------------------------------------------------------------------
  initial begin
    lanes_t lanes;
    in_t    blk;
    int     pick;
    int     nbits;
    int     bitpos;

    // All zero, all one and the two checkerboards.
    lanes = '0;                          blk = lanes; block_pending.push_back(blk);
    lanes = '1;                          blk = lanes; block_pending.push_back(blk);
    lanes = {8{64'h5555_5555_5555_5555}}; blk = lanes; block_pending.push_back(blk);
    lanes = {8{64'hAAAA_AAAA_AAAA_AAAA}}; blk = lanes; block_pending.push_back(blk);
    // Only the top bit, then only the bottom bit, of every word.
    lanes = {8{64'h8000_0000_8000_0000}}; blk = lanes; block_pending.push_back(blk);
    lanes = {8{64'h0000_0001_0000_0001}}; blk = lanes; block_pending.push_back(blk);
    // Every word at its maximum in the low halves only, then the high halves.
    lanes = {8{64'h0000_0000_FFFF_FFFF}}; blk = lanes; block_pending.push_back(blk);
    lanes = {8{64'hFFFF_FFFF_0000_0000}}; blk = lanes; block_pending.push_back(blk);
    // Word i holds i, then byte j holds j.
    for (int k = 0; k < 8; k++) begin
      lanes[7-k] = {32'(2*k+1), 32'(2*k)};
    end
    blk = lanes; block_pending.push_back(blk);
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < 8; j++) begin
        lanes[7-k][8*j +: 8] = 8'(8*k + j);
      end
    end
    blk = lanes; block_pending.push_back(blk);
    // One field at its maximum, all others zero.
    for (int k = 0; k < 8; k++) begin
      lanes = '0;
      lanes[7-k] = '1;
      blk = lanes; block_pending.push_back(blk);
    end
    // A single set bit at the lowest bit of word 0 and the top bit of word 15.
    lanes = '0; lanes[7][0]  = 1'b1; blk = lanes; block_pending.push_back(blk);
    lanes = '0; lanes[0][63] = 1'b1; blk = lanes; block_pending.push_back(blk);

    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      pick = $urandom_range(0, 15);
      if (pick < 2) begin
        // Sparse block: a handful of set bits.
        lanes = '0;
        nbits = $urandom_range(1, 6);
        for (int b = 0; b < nbits; b++) begin
          bitpos = $urandom_range(0, 511);
          lanes[bitpos / 64][bitpos % 64] = 1'b1;
        end
      end else if (pick == 2) begin
        // Nearly all ones: a handful of cleared bits.
        lanes = '1;
        nbits = $urandom_range(1, 6);
        for (int b = 0; b < nbits; b++) begin
          bitpos = $urandom_range(0, 511);
          lanes[bitpos / 64][bitpos % 64] = 1'b0;
        end
      end else begin
        for (int k = 0; k < 8; k++) begin
          lanes[k] = {$urandom(), $urandom()};
        end
      end
      blk = lanes;
      block_pending.push_back(blk);
    end
  end

  // Reset is held at the start of the run and never again.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Driver. Each block waits a random number of idle cycles before it is
  // offered; once valid is raised it stays up with the same data until the
  // transaction is taken. Stretches of back-to-back traffic come from the
  // burst flag, which flips now and then. While the receiver is held off the
  // driver keeps offering with no gaps so the pipeline fills and back-pressure
  // reaches the input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    if (rst) begin
      block_valid <= 1'b0;
      gap_left    <= $urandom_range(0, 15);
    end else begin
      if (block_valid && block_ready) begin
        perm_expected.push_back(chacha_image(block_data));
      end
      if (!block_valid || block_ready) begin
        if (gap_left > 0 && !hold_off) begin
          gap_left    <= gap_left - 1;
          block_valid <= 1'b0;
        end else if (block_pending.size() > 0) begin
          block_data  <= block_pending.pop_front();
          block_valid <= 1'b1;
          gap_left    <= (tx_burst || hold_off) ? 0 : $urandom_range(0, 15);
        end else begin
          block_valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 99) == 0) begin
        tx_burst <= !tx_burst;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Every accepted result is checked against the oldest prediction,
  // one 64-bit field at a time. After each result the receiver stalls for a
  // random number of cycles, unless it is in a burst stretch, and it stays
  // stalled for as long as the long hold-off is active.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    int     stall_n;
    out_t   want;
    lanes_t want_lanes;
    lanes_t got_lanes;
    if (rst) begin
      perm_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      stall_n = stall_left;
      if (perm_valid && perm_ready) begin
        results_seen <= results_seen + 1;
        if (perm_expected.size() == 0) begin
          flag_error($sformatf("Unexpected result transaction at cycle %0d: %h",
                               cycle_count, perm_data));
        end else begin
          want       = perm_expected.pop_front();
          want_lanes = want;
          got_lanes  = perm_data;
          for (int k = 0; k < 8; k++) begin
            if (got_lanes[7-k] !== want_lanes[7-k]) begin
              flag_error($sformatf(
                "Mismatch in out_block%0d at result %0d: expected %h, got %h",
                k, results_seen, want_lanes[7-k], got_lanes[7-k]));
            end
          end
        end
        stall_n = rx_burst ? 0 : $urandom_range(0, 15);
      end else if (stall_n > 0) begin
        stall_n = stall_n - 1;
      end
      stall_left <= stall_n;
      perm_ready <= (stall_n == 0) && !hold_off;
      if ($urandom_range(0, 99) == 0) begin
        rx_burst <= !rx_burst;
      end
    end
  end

  // One long receiver hold-off, counted here in cycles, once a few hundred
  // results have gone by. It is long enough to fill all pipeline stages.
  always @(posedge clk) begin : hold_control
    if (rst) begin
      hold_off  <= 1'b0;
      hold_done <= 1'b0;
      hold_left <= 0;
    end else if (hold_off) begin
      if (hold_left == 0) begin
        hold_off  <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_left <= hold_left - 1;
      end
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_off  <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // End of run. Once every block has been taken and every prediction has been
  // matched, wait a further stretch longer than the pipeline so that any
  // spurious extra result would still show up at the monitor.
  // --------------------------------------------------------------------------
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    while (block_pending.size() > 0 || block_valid || perm_expected.size() > 0) begin
      @(negedge clk);
    end
    repeat (2 * NUM_STAGES + 20) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
